FILE: design/drs_pkg.sv
// Shared types, constants and helpers for the diagnostic request sequencer.
// No dependencies; imported by every module of the block but drs_ram.
package drs_pkg;

    localparam int MAX_STEPS = 16;
    localparam int STEP_AW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int STEPS_W   = 5;
    localparam int STEP_CW   = $clog2(MAX_STEPS + 1);
    localparam int CNT_W     = (STEP_CW > STEPS_W) ? STEP_CW : STEPS_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_BUS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd4;

    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

    // event codes
    localparam logic [2:0] FN_POLL  = 3'd0;
    localparam logic [2:0] FN_RESP  = 3'd1;
    localparam logic [2:0] FN_START = 3'd2;
    localparam logic [2:0] FN_STOP  = 3'd3;
    localparam logic [2:0] FN_LOAD  = 3'd4;

    localparam logic [3:0] DLC_MAX     = 4'd8;
    localparam logic [3:0] DLC_MIN_RSP = 4'd2;
    localparam logic [7:0] SID_POS_OFS = 8'h40;

    typedef enum logic [1:0] {
        RS_IDLE     = 2'd0,
        RS_RUNNING  = 2'd1,
        RS_COMPLETE = 2'd2,
        RS_ERROR    = 2'd3
    } run_state_t;

    typedef struct packed {
        logic [1:0]         bus;
        logic [28:0]        ident;
        logic               extended;
        logic [31:0]        timeout;
        logic [STEPS_W-1:0] steps;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [15:0] delay;
    } step_t;

    typedef struct packed {
        logic               s1_stall;   // execute stage full and cannot retire
        logic               step_hazard; // item in execute may move the step
        logic [STEP_AW-1:0] rd_step;    // table index for the next read
    } eng_status_t;

    // keep bytes below dlc, clear the rest
    function automatic logic [63:0] dlc_mask(input logic [3:0] dlc);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < dlc) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: design/drs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/drs_cfg_regs.sv
// Configuration register file of the sequencer.
// Depends on drs_pkg.
module drs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [drs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output drs_pkg::cfg_t                     cfg
);
    import drs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BUS:      cfg_next.bus      = cfg_wdata[1:0];
                CFG_IDENT:    cfg_next.ident    = cfg_wdata[28:0];
                CFG_EXTENDED: cfg_next.extended = cfg_wdata[0];
                CFG_TIMEOUT:  cfg_next.timeout  = cfg_wdata[31:0];
                CFG_STEPS:    cfg_next.steps    = cfg_wdata[STEPS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bus      <= '0;
            cfg_reg.ident    <= '0;
            cfg_reg.extended <= 1'b0;
            cfg_reg.timeout  <= TIMEOUT_RESET;
            cfg_reg.steps    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/drs_engine.sv
// Execute stage: sequence state, step decisions and the result register.
// Depends on drs_pkg; step entry arrives from the table RAM read issued at accept.
module drs_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [2:0]           in_func,
    input  logic [31:0]          in_now,
    input  logic [7:0]           in_sid,
    input  drs_pkg::step_t       step_rd,
    input  drs_pkg::cfg_t        cfg,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_frame_valid,
    output logic [1:0]           m_frame_bus,
    output logic [28:0]          m_frame_identifier,
    output logic                 m_frame_extended,
    output logic [3:0]           m_frame_dlc,
    output logic [63:0]          m_frame_data,
    output logic [31:0]          m_frame_time_ms,
    output logic                 m_response_accepted,
    output logic [1:0]           m_sequence_state,
    output drs_pkg::eng_status_t status
);
    import drs_pkg::*;

    // execute stage item
    logic        s1_valid_reg, s1_valid_next;
    logic [2:0]  s1_func_reg;
    logic [31:0] s1_now_reg;
    logic [7:0]  s1_sid_reg;

    // sequence state
    run_state_t       run_state_reg, run_state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [31:0]      last_send_reg, last_send_next;
    logic [31:0]      start_reg, start_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        fv_reg, fv_next;
    logic [1:0]  bus_reg, bus_next;
    logic [28:0] ident_reg, ident_next;
    logic        ext_reg, ext_next;
    logic [3:0]  dlc_reg, dlc_next;
    logic [63:0] data_reg, data_next;
    logic [31:0] ftime_reg, ftime_next;
    logic        acc_reg, acc_next;
    logic [1:0]  state_reg, state_next;

    logic             s1_fire;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] steps_ext;
    logic [CNT_W-1:0] step_inc;
    logic             in_range;
    logic [31:0]      since_start;
    logic [31:0]      since_send;
    logic             timed_out;
    logic             delay_met;
    logic             sid_match;

    assign s1_fire   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign steps_ext = CNT_W'(cfg.steps);
    assign total     = (steps_ext < CNT_W'(MAX_STEPS)) ? steps_ext : CNT_W'(MAX_STEPS);
    assign in_range  = step_reg < total;
    assign step_inc  = step_reg + CNT_W'(1);

    assign since_start = s1_now_reg - start_reg;
    assign since_send  = s1_now_reg - last_send_reg;
    assign timed_out   = (cfg.timeout != '0) && (since_start > cfg.timeout);
    assign delay_met   = (last_send_reg == '0) || (since_send >= 32'(step_rd.delay));
    assign sid_match   = s1_sid_reg == (step_rd.payload[15:8] + SID_POS_OFS);

    always_comb begin
        s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
        run_state_next = run_state_reg;
        step_next      = step_reg;
        last_send_next = last_send_reg;
        start_next     = start_reg;

        m_valid_next = s1_fire || (m_valid_reg && !m_ready);
        fv_next      = fv_reg;
        bus_next     = bus_reg;
        ident_next   = ident_reg;
        ext_next     = ext_reg;
        dlc_next     = dlc_reg;
        data_next    = data_reg;
        ftime_next   = ftime_reg;
        acc_next     = acc_reg;

        if (s1_fire) begin
            fv_next    = 1'b0;
            bus_next   = '0;
            ident_next = '0;
            ext_next   = 1'b0;
            dlc_next   = '0;
            data_next  = '0;
            ftime_next = '0;
            acc_next   = 1'b0;
            case (s1_func_reg)
                FN_POLL: begin
                    if (run_state_reg == RS_RUNNING) begin
                        if (!in_range) begin
                            run_state_next = RS_COMPLETE;
                        end else if (timed_out) begin
                            run_state_next = RS_ERROR;
                        end else if (delay_met) begin
                            fv_next        = 1'b1;
                            bus_next       = cfg.bus;
                            ident_next     = cfg.ident;
                            ext_next       = cfg.extended;
                            dlc_next       = step_rd.dlc;
                            data_next      = step_rd.payload;
                            ftime_next     = s1_now_reg;
                            last_send_next = s1_now_reg;
                        end
                    end
                end
                FN_RESP: begin
                    if (run_state_reg == RS_RUNNING && in_range &&
                        step_rd.dlc >= DLC_MIN_RSP && sid_match) begin
                        step_next      = step_inc;
                        last_send_next = s1_now_reg;
                        acc_next       = 1'b1;
                        if (step_inc >= total) begin
                            run_state_next = RS_COMPLETE;
                        end
                    end
                end
                FN_START: begin
                    if (total != '0) begin
                        step_next      = '0;
                        run_state_next = RS_RUNNING;
                        last_send_next = '0;
                        start_next     = s1_now_reg;
                    end
                end
                FN_STOP: begin
                    run_state_next = RS_IDLE;
                    step_next      = '0;
                end
                default: begin
                    // loads are written at accept; unknown events change nothing
                end
            endcase
        end
        state_next = s1_fire ? 2'(run_state_next) : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            run_state_reg <= RS_IDLE;
            step_reg      <= '0;
            last_send_reg <= '0;
            start_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            run_state_reg <= run_state_next;
            step_reg      <= step_next;
            last_send_reg <= last_send_next;
            start_reg     <= start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_func_reg <= in_func;
            s1_now_reg  <= in_now;
            s1_sid_reg  <= in_sid;
        end
        fv_reg    <= fv_next;
        bus_reg   <= bus_next;
        ident_reg <= ident_next;
        ext_reg   <= ext_next;
        dlc_reg   <= dlc_next;
        data_reg  <= data_next;
        ftime_reg <= ftime_next;
        acc_reg   <= acc_next;
        state_reg <= state_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_frame_valid       = fv_reg;
    assign m_frame_bus         = bus_reg;
    assign m_frame_identifier  = ident_reg;
    assign m_frame_extended    = ext_reg;
    assign m_frame_dlc         = dlc_reg;
    assign m_frame_data        = data_reg;
    assign m_frame_time_ms     = ftime_reg;
    assign m_response_accepted = acc_reg;
    assign m_sequence_state    = state_reg;

    assign status.s1_stall    = s1_valid_reg && !s1_fire;
    assign status.step_hazard = s1_valid_reg &&
                                (s1_func_reg == FN_RESP || s1_func_reg == FN_START ||
                                 s1_func_reg == FN_STOP);
    assign status.rd_step     = step_reg[STEP_AW-1:0];

endmodule

FILE: design/diag_request_sequencer_top.sv
// Top level of the diagnostic request sequencer: accept stage, step table RAM,
// configuration registers and execute stage. Depends on drs_pkg, drs_ram,
// drs_cfg_regs and drs_engine.
//
//   channel  | handshake            | moves
//   ---------+----------------------+-----------------------------------------
//   s_*      | s_valid / s_ready    | one event item (poll, resp, start, stop, load)
//   m_*      | m_valid / m_ready    | one result item per event
//   cfg_*    | cfg_wr_en            | register write, no wait, no read-back
//
// Two-stage pipe: the accept edge issues the step table read (and performs any
// load write); the execute stage then decides the event and fills the result
// register. An item behind a poll, load or unknown event may enter as it retires;
// after a response, start or stop, a poll or response waits until that item has
// left the execute stage, so that the step index settles first.
// A stalled m_ready holds the result; one more item may sit in the execute
// stage behind it before s_ready drops.
// Reset (synchronous, aresetn low) clears sequence state and registers; the
// step table holds no reset and each slot must be loaded before it is used.
module diag_request_sequencer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // event items in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_func,
    input  logic [31:0]                    s_now_time_ms,
    input  logic [7:0]                     s_response_sid,
    input  logic [3:0]                     s_load_slot,
    input  logic [3:0]                     s_load_dlc,
    input  logic [63:0]                    s_load_payload,
    input  logic [15:0]                    s_load_delay_ms,
    // result items out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_frame_valid,
    output logic [1:0]                     m_frame_bus,
    output logic [28:0]                    m_frame_identifier,
    output logic                           m_frame_extended,
    output logic [3:0]                     m_frame_dlc,
    output logic [63:0]                    m_frame_data,
    output logic [31:0]                    m_frame_time_ms,
    output logic                           m_response_accepted,
    output logic [1:0]                     m_sequence_state
);
    import drs_pkg::*;

    cfg_t        cfg;
    eng_status_t status;
    step_t       step_wr;
    step_t       step_rd;
    logic        in_fire;
    logic        reads_step;
    logic        slot_ok;
    logic        tbl_we;
    logic [3:0]  dlc_sat;

    // Polls and responses read the table at the current step, so they must
    // not enter while the item ahead may still move it.
    assign reads_step = (s_func == FN_POLL) || (s_func == FN_RESP);
    assign s_ready    = !status.s1_stall && !(status.step_hazard && reads_step);
    assign in_fire    = s_valid && s_ready;

    // Load: saturate the length and clear bytes past it before storing.
    assign dlc_sat         = (s_load_dlc > DLC_MAX) ? DLC_MAX : s_load_dlc;
    assign step_wr.dlc     = dlc_sat;
    assign step_wr.payload = s_load_payload & dlc_mask(dlc_sat);
    assign step_wr.delay   = s_load_delay_ms;
    assign slot_ok         = 32'(s_load_slot) < 32'(MAX_STEPS);
    assign tbl_we          = in_fire && (s_func == FN_LOAD) && slot_ok;

    drs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Step table: written at the load's accept edge, read at every accept,
    // so a later item always sees earlier loads without forwarding.
    drs_ram #(
        .WIDTH ($bits(step_t)),
        .DEPTH (MAX_STEPS),
        .AW    (STEP_AW)
    ) u_step_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (STEP_AW'(s_load_slot)),
        .wdata (step_wr),
        .re    (in_fire),
        .raddr (status.rd_step),
        .rdata (step_rd)
    );

    drs_engine u_eng (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_fire             (in_fire),
        .in_func             (s_func),
        .in_now              (s_now_time_ms),
        .in_sid              (s_response_sid),
        .step_rd             (step_rd),
        .cfg                 (cfg),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_frame_valid       (m_frame_valid),
        .m_frame_bus         (m_frame_bus),
        .m_frame_identifier  (m_frame_identifier),
        .m_frame_extended    (m_frame_extended),
        .m_frame_dlc         (m_frame_dlc),
        .m_frame_data        (m_frame_data),
        .m_frame_time_ms     (m_frame_time_ms),
        .m_response_accepted (m_response_accepted),
        .m_sequence_state    (m_sequence_state),
        .status              (status)
    );

endmodule

FILE: design/drs_checker.sv
// Port-level checks for the sequencer and the bind that attaches them.
// Depends on drs_pkg and diag_request_sequencer_top.
module drs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_frame_valid,
    input logic [1:0]  m_frame_bus,
    input logic [28:0] m_frame_identifier,
    input logic        m_frame_extended,
    input logic [3:0]  m_frame_dlc,
    input logic [63:0] m_frame_data,
    input logic [31:0] m_frame_time_ms,
    input logic        m_response_accepted,
    input logic [1:0]  m_sequence_state
);
    import drs_pkg::*;

    // a sent frame leaves the sequence running
    a_frame_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_valid |-> m_sequence_state == 2'(RS_RUNNING))
        else $error("frame sent outside running state");

    // one event cannot both send and accept a response
    a_send_or_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_valid && m_response_accepted))
        else $error("frame and response acceptance in one item");

    // no frame: all frame fields are zero
    a_idle_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_valid |->
            m_frame_dlc == '0 && m_frame_data == '0 && m_frame_time_ms == '0 &&
            m_frame_identifier == '0 && m_frame_bus == '0 && !m_frame_extended)
        else $error("frame fields set without a frame");

    // accepted response leaves running or complete
    a_accept_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_response_accepted |->
            m_sequence_state == 2'(RS_RUNNING) || m_sequence_state == 2'(RS_COMPLETE))
        else $error("response accepted in a wrong state");

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_data) &&
            $stable(m_sequence_state))
        else $error("result changed while stalled");

endmodule

bind diag_request_sequencer_top drs_checker u_drs_checker (.*);

FILE: sim/tb_diag_request_sequencer_top.sv
// Self-checking bench for diag_request_sequencer_top. Event items are driven with
// random gaps outside no-idle phases; every result item is predicted and compared
// field by field. Depends on drs_pkg and the sequencer RTL.
module tb_diag_request_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import drs_pkg::*;

    // highest encodable func; codes above FN_LOAD are unknown events
    localparam logic [2:0] FN_LAST       = 3'd7;
    localparam int         N_PHASES      = 10;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         EMPTY_ITEMS   = 30;    // phase with no steps in use
    localparam int         MAX_GAP       = 6;
    localparam int         SETTLE_CYCLES = 8;     // two-stage pipe plus margin
    localparam int         RUN_LIMIT_NS  = 2_000_000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [7:0]  sid;
        logic [3:0]  slot;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [15:0] delay;
    } event_item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [1:0]  bus;
        logic [28:0] ident;
        logic        extended;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [31:0] stamp;
        logic        accepted;
        run_state_t  state;
    } result_item_t;

    // Own copy of the sequencer: registers, run state and step table, plus the
    // queue of result items still owed by the block.
    class sequence_scoreboard;
        logic [1:0]   bus_sel;
        logic [28:0]  req_id;
        logic         ext_fmt;
        logic [31:0]  limit_ms;
        logic [4:0]   steps_used;
        run_state_t   state;
        logic [4:0]   cur_step;
        logic [31:0]  last_sent;
        logic [31:0]  started_at;
        logic [3:0]   lens [MAX_STEPS];
        logic [63:0]  pays [MAX_STEPS];
        logic [15:0]  gaps [MAX_STEPS];
        result_item_t due_results [$];
        int           errors;

        function new();
            bus_sel    = '0;
            req_id     = '0;
            ext_fmt    = 1'b0;
            limit_ms   = TIMEOUT_RESET;
            steps_used = '0;
            state      = RS_IDLE;
            cur_step   = '0;
            last_sent  = '0;
            started_at = '0;
            errors     = 0;
            for (int i = 0; i < MAX_STEPS; i++) begin
                lens[i] = '0;
                pays[i] = '0;
                gaps[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_BUS:      bus_sel    = val[1:0];
                CFG_IDENT:    req_id     = val[28:0];
                CFG_EXTENDED: ext_fmt    = val[0];
                CFG_TIMEOUT:  limit_ms   = val;
                CFG_STEPS:    steps_used = val[4:0];
                default: ;
            endcase
        endfunction

        function void note_event(event_item_t ev);
            result_item_t r;
            logic [4:0]   total;
            logic [3:0]   idx;
            logic [3:0]   len;
            logic [31:0]  since;
            logic [7:0]   want_sid;
            r     = '0;
            total = (steps_used > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : steps_used;
            idx   = cur_step[3:0];
            case (ev.func)
                FN_POLL: begin
                    if (state == RS_RUNNING) begin
                        since = ev.now - started_at;
                        if (cur_step >= total) begin
                            state = RS_COMPLETE;
                        end else if (limit_ms != 0 && since > limit_ms) begin
                            state = RS_ERROR;
                        end else begin
                            since = ev.now - last_sent;
                            // a zero send time means nothing sent yet: no delay check
                            if (last_sent == 0 || since >= 32'(gaps[idx])) begin
                                r.frame_valid = 1'b1;
                                r.bus         = bus_sel;
                                r.ident       = req_id;
                                r.extended    = ext_fmt;
                                r.dlc         = lens[idx];
                                r.data        = pays[idx];
                                r.stamp       = ev.now;
                                last_sent     = ev.now;
                            end
                        end
                    end
                end
                FN_RESP: begin
                    want_sid = pays[idx][15:8] + SID_POS_OFS;
                    if (state == RS_RUNNING && cur_step < total && lens[idx] >= DLC_MIN_RSP
                            && ev.sid == want_sid) begin
                        cur_step   = cur_step + 5'd1;
                        last_sent  = ev.now;
                        r.accepted = 1'b1;
                        if (cur_step >= total) state = RS_COMPLETE;
                    end
                end
                FN_START: begin
                    if (total != 0) begin
                        cur_step   = '0;
                        state      = RS_RUNNING;
                        last_sent  = '0;
                        started_at = ev.now;
                    end
                end
                FN_STOP: begin
                    state    = RS_IDLE;
                    cur_step = '0;
                end
                FN_LOAD: begin
                    len            = (ev.dlc > DLC_MAX) ? DLC_MAX : ev.dlc;
                    lens[ev.slot]  = len;
                    pays[ev.slot]  = ev.payload &
                                     ((len >= DLC_MAX) ? '1 : (64'd1 << (len * 8)) - 64'd1);
                    gaps[ev.slot]  = ev.delay;
                end
                default: ;
            endcase
            r.state = state;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result item expected none actual state %0d",
                         $time, got.state);
                return;
            end
            want = due_results.pop_front();
            compare_field("frame_valid", want.frame_valid, got.frame_valid);
            compare_field("frame_bus", want.bus, got.bus);
            compare_field("frame_identifier", want.ident, got.ident);
            compare_field("frame_extended", want.extended, got.extended);
            compare_field("frame_dlc", want.dlc, got.dlc);
            compare_field("frame_data", want.data, got.data);
            compare_field("frame_time_ms", want.stamp, got.stamp);
            compare_field("response_accepted", want.accepted, got.accepted);
            compare_field("sequence_state", want.state, got.state);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [2:0]            s_func;
    logic [31:0]           s_now_time_ms;
    logic [7:0]            s_response_sid;
    logic [3:0]            s_load_slot;
    logic [3:0]            s_load_dlc;
    logic [63:0]           s_load_payload;
    logic [15:0]           s_load_delay_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_frame_valid;
    logic [1:0]            m_frame_bus;
    logic [28:0]           m_frame_identifier;
    logic                  m_frame_extended;
    logic [3:0]            m_frame_dlc;
    logic [63:0]           m_frame_data;
    logic [31:0]           m_frame_time_ms;
    logic                  m_response_accepted;
    logic [1:0]            m_sequence_state;

    sequence_scoreboard sb = new();
    logic [31:0]        clock_ms = '0;  // millisecond stamp carried by the items
    bit                 no_idle  = 1'b0; // both sides run flat out while set

    diag_request_sequencer_top uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_now_time_ms       (s_now_time_ms),
        .s_response_sid      (s_response_sid),
        .s_load_slot         (s_load_slot),
        .s_load_dlc          (s_load_dlc),
        .s_load_payload      (s_load_payload),
        .s_load_delay_ms     (s_load_delay_ms),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_valid       (m_frame_valid),
        .m_frame_bus         (m_frame_bus),
        .m_frame_identifier  (m_frame_identifier),
        .m_frame_extended    (m_frame_extended),
        .m_frame_dlc         (m_frame_dlc),
        .m_frame_data        (m_frame_data),
        .m_frame_time_ms     (m_frame_time_ms),
        .m_response_accepted (m_response_accepted),
        .m_sequence_state    (m_sequence_state)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every field random so that all input bits toggle; callers override what
    // the event needs.
    function automatic event_item_t noise_item(logic [2:0] func);
        event_item_t ev;
        ev.func    = func;
        ev.now     = clock_ms;
        ev.sid     = 8'($urandom);
        ev.slot    = 4'($urandom);
        ev.dlc     = 4'($urandom);
        ev.payload = {$urandom, $urandom};
        ev.delay   = 16'($urandom);
        return ev;
    endfunction

    // Outputs are sampled and inputs driven at the rising edge. Reads taken
    // straight after the edge see pre-edge values, as all updates are NBAs.
    task automatic send_item(input event_item_t ev);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= ev.func;
        s_now_time_ms   <= ev.now;
        s_response_sid  <= ev.sid;
        s_load_slot     <= ev.slot;
        s_load_dlc      <= ev.dlc;
        s_load_payload  <= ev.payload;
        s_load_delay_ms <= ev.delay;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_event(ev);
    endtask

    // Lowers valid and waits for every owed result item, then lets the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; program_regs lowers it after the batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [1:0] bus, input logic [28:0] ident,
                                input logic ext, input logic [31:0] tmo,
                                input logic [4:0] steps);
        write_reg(CFG_BUS, 32'(bus));
        write_reg(CFG_IDENT, 32'(ident));
        write_reg(CFG_EXTENDED, 32'(ext));
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_STEPS, 32'(steps));
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic: mostly well-formed start / poll / matching-response runs,
    // with loads, stops, restarts, wrong SIDs and unknown codes mixed in.
    task automatic build_item(output event_item_t ev);
        int         roll;
        logic [3:0] idx;
        roll = $urandom_range(0, 99);
        idx  = sb.cur_step[3:0];
        // occasional large jump: wraps the stamp and ages out long delays
        if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 12);
        ev = noise_item(3'($urandom_range(0, FN_LAST)));
        if (roll < 6) begin
            // keep the random code, unknown ones included
        end else if (roll < 12) begin
            ev.func = FN_LOAD;
            if ($urandom_range(0, 3) != 0) ev.delay = 16'($urandom_range(0, 40));
        end else if (sb.state != RS_RUNNING) begin
            ev.func = (roll < 80) ? FN_START : (roll < 92) ? FN_POLL : FN_STOP;
        end else if (roll < 14) begin
            ev.func = FN_STOP;
        end else if (roll < 16) begin
            ev.func = FN_START;
        end else if (roll < 65) begin
            ev.func = FN_POLL;
        end else begin
            ev.func = FN_RESP;
            if (roll < 92 && sb.cur_step < 5'(MAX_STEPS))
                ev.sid = sb.pays[idx][15:8] + SID_POS_OFS;
        end
    endtask

    initial begin : stimulus
        event_item_t ev;
        logic [31:0] tmo;
        logic [4:0]  steps;
        int          n_items;

        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_func          <= FN_POLL;
        s_now_time_ms   <= '0;
        s_response_sid  <= '0;
        s_load_slot     <= '0;
        s_load_dlc      <= '0;
        s_load_payload  <= '0;
        s_load_delay_ms <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- reset settings: no steps in use -----------------------------
        clock_ms = 32'd100;
        for (int f = FN_LOAD + 1; f <= FN_LAST; f++) send_item(noise_item(3'(f)));
        send_item(noise_item(FN_START));    // no steps: start is ignored
        send_item(noise_item(FN_RESP));     // response while idle
        // fill the whole table before anything can read it, edges first
        for (int slot = 0; slot < MAX_STEPS; slot++) begin
            ev      = noise_item(FN_LOAD);
            ev.slot = 4'(slot);
            ev.dlc  = 4'($urandom_range(DLC_MIN_RSP, DLC_MAX));
            ev.delay = 16'($urandom_range(0, 30));
            case (slot)
                0: begin ev.dlc = 4'hF; ev.payload = '1; ev.delay = '0; end // saturates
                1: begin ev.dlc = '0; ev.payload = '1; ev.delay = '1; end
                2: begin ev.dlc = 4'd1; ev.delay = '0; end
                3: begin ev.dlc = DLC_MIN_RSP; ev.payload[15:8] = 8'hC0; ev.delay = '1; end
                4: begin ev.dlc = DLC_MAX; ev.payload = '0; ev.delay = '0; end
                default: ;
            endcase
            send_item(ev);
        end

        // --- all registers at their top values, timeout off ---------------
        drain();
        program_regs(2'd3, '1, 1'b1, '0, 5'(MAX_STEPS));
        clock_ms = 32'hFFFF_FFF0;
        send_item(noise_item(FN_START));
        send_item(noise_item(FN_POLL));     // first send skips the delay check
        clock_ms = clock_ms + 1;
        send_item(noise_item(FN_POLL));     // zero delay: sends again
        clock_ms = clock_ms + 1;
        ev     = noise_item(FN_RESP);
        ev.sid = 8'hFF + SID_POS_OFS;       // SID sum wraps
        send_item(ev);
        clock_ms = 32'd5;                   // stamp wraps; long delay not yet over
        send_item(noise_item(FN_POLL));
        ev     = noise_item(FN_RESP);
        ev.sid = SID_POS_OFS;               // would match, but the step is too short
        send_item(ev);

        // --- bottom values: poll past the end, then the timeout -----------
        drain();
        program_regs('0, '0, 1'b0, TIMEOUT_RESET, 5'd1);
        send_item(noise_item(FN_POLL));     // step 1 of 1: sequence complete
        send_item(noise_item(FN_STOP));
        clock_ms = 32'd1000;
        send_item(noise_item(FN_START));
        clock_ms = clock_ms + TIMEOUT_RESET + 1;
        send_item(noise_item(FN_POLL));     // timeout exceeded: error

        // --- random phases, each with its own settings --------------------
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 5)
                0: tmo = '0;
                1: tmo = '1;
                2: tmo = $urandom_range(30, 600);
                3: tmo = TIMEOUT_RESET;
                default: tmo = $urandom_range(1, 3);
            endcase
            if (ph == 3) steps = '0;
            else if (ph == 1) steps = 5'd1;
            else if (ph == 5 || ph == 9) steps = 5'(MAX_STEPS);
            else steps = 5'($urandom_range(1, 6));
            drain();
            program_regs(2'(ph), (ph == 1) ? '1 : 29'($urandom), ph[0], tmo, steps);
            // every third phase runs with no gaps on either side
            no_idle = (ph % 3 == 2);
            n_items = (steps == 0) ? EMPTY_ITEMS : PHASE_ITEMS;
            repeat (n_items) begin
                build_item(ev);
                send_item(ev);
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: a fresh stall for every result item, then wait for valid.
    initial begin : result_side
        int           stall;
        result_item_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got.frame_valid = m_frame_valid;
            got.bus         = m_frame_bus;
            got.ident       = m_frame_identifier;
            got.extended    = m_frame_extended;
            got.dlc         = m_frame_dlc;
            got.data        = m_frame_data;
            got.stamp       = m_frame_time_ms;
            got.accepted    = m_response_accepted;
            got.state       = run_state_t'(m_sequence_state);
            sb.check_result(got);
        end
    end

    // Hang guard, well beyond the slowest legal run.
    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
